[sv/svc_pkg.sv]
// Package for the sprite VM core: item types, opcodes, geometry constants,
// the font table and the sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svc_pkg;

  localparam int DisplayWidth  = 64;
  localparam int DisplayHeight = 32;
  localparam int MemoryBytes   = 4096;

  localparam int MemAw = $clog2(MemoryBytes);
  localparam int ColW  = $clog2(DisplayWidth);
  localparam int RowW  = $clog2(DisplayHeight);

  localparam logic [11:0] FontBase = 12'h050;
  localparam logic [11:0] PcReset  = 12'h200;
  localparam logic [15:0] ClsWord  = 16'h00E0;
  localparam int          FontLen  = 80;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EXEC  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } item_op_e;

  typedef enum logic [3:0] {
    OPC_SYS = 4'h0,
    OPC_JP  = 4'h1,
    OPC_LD  = 4'h6,
    OPC_ADD = 4'h7,
    OPC_LDI = 4'hA,
    OPC_DRW = 4'hD
  } opcode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH1,
    ST_FETCH2,
    ST_EXEC,
    ST_ADD,
    ST_DRAWX,
    ST_DRAWY,
    ST_ROWRD,
    ST_ROWMOD,
    ST_DRAWFIN,
    ST_ROWOUT
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [4:0]  row_select;
  } item_in_t;

  typedef struct packed {
    logic [63:0] row_pixels;
    logic [11:0] pc_after;
    logic [15:0] instruction;
    logic        collision;
    logic        unsupported;
  } item_out_t;

  localparam logic [7:0] Glyphs [FontLen] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Power-up content of one memory byte: font glyphs or zero.
  function automatic logic [7:0] boot_byte(input logic [MemAw-1:0] addr);
    logic [11:0] a;
    logic [11:0] off;
    a   = 12'(addr);
    off = a - FontBase;
    if (a >= FontBase && off < 12'(FontLen)) begin
      return Glyphs[off[6:0]];
    end
    return 8'h00;
  endfunction

endpackage
`default_nettype wire

[sv/svc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module svc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[sv/sprite_vm_core_subset_core.sv]
// Top level of the sprite VM core: sequencer around three RAMs.
// Depends on svc_pkg and svc_ram.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Command channel: an item (in_i) is taken at a rising edge with start
//   high and busy low. op selects a memory byte write, one instruction, or
//   a display row read. Every item yields exactly one result on res_o,
//   marked by res_valid_o for one cycle; the receiver cannot stall it.
//   States passed after the accept:
//     write byte / unused op: none; display row read: ROWOUT
//     CLS, jump, LD, LD I:    FETCH1, FETCH2, EXEC; ADD also ST_ADD
//     sprite draw Dxyn:       FETCH1, FETCH2, EXEC, DRAWX, DRAWY, then per
//                             drawn row ROWRD and ROWMOD (n rows, clipped at
//                             the bottom edge), a last ROWRD and DRAWFIN
//   Busy drops in the cycle the result shows, so the next item may follow
//   at once. The sequence is set by the single read port of each RAM:
//   fetch takes two byte reads, a draw one read-modify-write per row.
//   Reset: a clearing pass writes all 4096 bytes of program memory (font
//   at 0x50, zero elsewhere); busy stays high meanwhile. Registers and
//   display rows reset through per-entry valid bits; CLS clears the row bits.
module sprite_vm_core_subset_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire svc_pkg::item_in_t  in_i,
  output logic                    res_valid_o,
  output svc_pkg::item_out_t      res_o
);
  localparam int Aw = svc_pkg::MemAw;
  localparam int Dw = svc_pkg::DisplayWidth;

  svc_pkg::state_e state_q, state_d;
  logic [Aw-1:0]   clr_q, clr_d;
  logic [11:0]     pc_q, pc_d, i_q, i_d;
  logic [7:0]      hi_q, hi_d;
  logic [15:0]     instr_q, instr_d;
  logic [svc_pkg::ColW-1:0] x0_q, x0_d;
  logic [svc_pkg::RowW-1:0] y0_q, y0_d;
  logic [3:0]      r_q, r_d;
  logic            hit_q, hit_d;
  logic [15:0]     vvalid_q, vvalid_d;
  logic [svc_pkg::DisplayHeight-1:0] dvalid_q, dvalid_d;
  svc_pkg::item_out_t res_q, res_d;
  logic            resv_q, resv_d;

  // memory ports
  logic            pm_we;
  logic [Aw-1:0]   pm_waddr, pm_raddr;
  logic [7:0]      pm_wdata, pm_rdata;
  logic            vr_we;
  logic [3:0]      vr_waddr, vr_raddr;
  logic [7:0]      vr_wdata, vr_rdata;
  logic            ds_we;
  logic [svc_pkg::RowW-1:0] ds_waddr, ds_raddr;
  logic [Dw-1:0]   ds_wdata, ds_rdata;

  svc_ram #(.Width(8), .Depth(svc_pkg::MemoryBytes)) u_prog_mem (
    .clk_i, .we_i(pm_we), .waddr_i(pm_waddr), .wdata_i(pm_wdata),
    .raddr_i(pm_raddr), .rdata_o(pm_rdata)
  );

  svc_ram #(.Width(8), .Depth(16)) u_vreg_mem (
    .clk_i, .we_i(vr_we), .waddr_i(vr_waddr), .wdata_i(vr_wdata),
    .raddr_i(vr_raddr), .rdata_o(vr_rdata)
  );

  svc_ram #(.Width(Dw), .Depth(svc_pkg::DisplayHeight)) u_disp_mem (
    .clk_i, .we_i(ds_we), .waddr_i(ds_waddr), .wdata_i(ds_wdata),
    .raddr_i(ds_raddr), .rdata_o(ds_rdata)
  );

  // decoded fields of the held instruction
  logic [3:0]  opc, vx, vy, nn;
  logic [7:0]  kk;
  logic [11:0] nnn;
  assign opc = instr_q[15:12];
  assign vx  = instr_q[11:8];
  assign vy  = instr_q[7:4];
  assign nn  = instr_q[3:0];
  assign kk  = instr_q[7:0];
  assign nnn = instr_q[11:0];

  logic [3:0] vr_raddr_q;
  logic [svc_pkg::RowW-1:0] ds_raddr_q;
  // row requested by a read item, kept for the range check
  logic [4:0] in_row_q;

  // register read value: never-written entries read as zero
  logic [7:0] vval;
  always_comb begin
    vval = vvalid_q[vr_raddr_q] ? vr_rdata : 8'h00;
  end

  // draw row arithmetic
  logic [svc_pkg::RowW+4:0] yabs;
  logic [Dw-1:0]            drow, spr;
  logic [Aw-1:0]            rd_row_addr;
  assign yabs = (svc_pkg::RowW+5)'(y0_q) + (svc_pkg::RowW+5)'(r_q);
  assign drow = dvalid_q[ds_raddr_q] ? ds_rdata : '0;
  assign spr  = (Dw'(pm_rdata) << (Dw - 8)) >> x0_q;
  logic [11:0] ir_sum;
  assign ir_sum = i_q + 12'(r_q);
  assign rd_row_addr = ir_sum[Aw-1:0];

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    pc_d     = pc_q;
    i_d      = i_q;
    hi_d     = hi_q;
    instr_d  = instr_q;
    x0_d     = x0_q;
    y0_d     = y0_q;
    r_d      = r_q;
    hit_d    = hit_q;
    vvalid_d = vvalid_q;
    dvalid_d = dvalid_q;
    res_d    = res_q;
    resv_d   = 1'b0;
    pm_we    = 1'b0;
    pm_waddr = clr_q;
    pm_wdata = svc_pkg::boot_byte(clr_q);
    pm_raddr = pc_q[Aw-1:0];
    vr_we    = 1'b0;
    vr_waddr = vx;
    vr_wdata = kk;
    vr_raddr = vx;
    ds_we    = 1'b0;
    ds_waddr = yabs[svc_pkg::RowW-1:0];
    ds_wdata = drow ^ spr;
    ds_raddr = yabs[svc_pkg::RowW-1:0];

    unique case (state_q)
      svc_pkg::ST_CLEAR: begin
        pm_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == Aw'(svc_pkg::MemoryBytes - 1)) begin
          state_d = svc_pkg::ST_IDLE;
        end
      end
      svc_pkg::ST_IDLE: begin
        if (start) begin
          res_d = '0;
          res_d.pc_after = pc_q;
          unique case (svc_pkg::item_op_e'(in_i.op))
            svc_pkg::OP_WRITE: begin
              pm_we    = 1'b1;
              pm_waddr = in_i.mem_address[Aw-1:0];
              pm_wdata = in_i.mem_data;
              resv_d   = 1'b1;
            end
            svc_pkg::OP_EXEC: begin
              state_d = svc_pkg::ST_FETCH1;
            end
            svc_pkg::OP_READ: begin
              ds_raddr = in_i.row_select[svc_pkg::RowW-1:0];
              state_d  = svc_pkg::ST_ROWOUT;
            end
            svc_pkg::OP_NONE: begin
              resv_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      svc_pkg::ST_ROWOUT: begin
        if (32'(in_row_q) < svc_pkg::DisplayHeight) begin
          res_d.row_pixels = 64'(drow) << (64 - Dw);
        end
        resv_d  = 1'b1;
        state_d = svc_pkg::ST_IDLE;
      end
      svc_pkg::ST_FETCH1: begin
        hi_d     = pm_rdata;
        pm_raddr = pc_q[Aw-1:0] + 1'b1;
        state_d  = svc_pkg::ST_FETCH2;
      end
      svc_pkg::ST_FETCH2: begin
        instr_d = {hi_q, pm_rdata};
        pc_d    = pc_q + 12'd2;
        state_d = svc_pkg::ST_EXEC;
      end
      svc_pkg::ST_EXEC: begin
        res_d.instruction = instr_q;
        state_d = svc_pkg::ST_IDLE;
        resv_d  = 1'b1;
        unique case (opc)
          svc_pkg::OPC_SYS: begin
            if (instr_q == svc_pkg::ClsWord) begin
              dvalid_d = '0;
            end else begin
              res_d.unsupported = 1'b1;
            end
          end
          svc_pkg::OPC_JP:  pc_d = nnn;
          svc_pkg::OPC_LD: begin
            vr_we        = 1'b1;
            vvalid_d[vx] = 1'b1;
          end
          svc_pkg::OPC_ADD: begin
            resv_d  = 1'b0;
            state_d = svc_pkg::ST_ADD;
          end
          svc_pkg::OPC_LDI: i_d = nnn;
          svc_pkg::OPC_DRW: begin
            resv_d  = 1'b0;
            state_d = svc_pkg::ST_DRAWX;
          end
          default: res_d.unsupported = 1'b1;
        endcase
        res_d.pc_after = pc_d;
      end
      svc_pkg::ST_ADD: begin
        vr_we        = 1'b1;
        vr_wdata     = vval + kk;
        vvalid_d[vx] = 1'b1;
        resv_d       = 1'b1;
        state_d      = svc_pkg::ST_IDLE;
      end
      svc_pkg::ST_DRAWX: begin
        // origin wraps: width is a power of two, so keep the low bits
        x0_d     = vval[svc_pkg::ColW-1:0];
        vr_raddr = vy;
        state_d  = svc_pkg::ST_DRAWY;
      end
      svc_pkg::ST_DRAWY: begin
        y0_d         = vval[svc_pkg::RowW-1:0];
        vr_we        = 1'b1;
        vr_waddr     = 4'hF;
        vr_wdata     = 8'h00;
        vvalid_d[15] = 1'b1;
        r_d          = '0;
        hit_d        = 1'b0;
        state_d      = svc_pkg::ST_ROWRD;
      end
      svc_pkg::ST_ROWRD: begin
        if (r_q == nn || 32'(yabs) >= svc_pkg::DisplayHeight) begin
          state_d = svc_pkg::ST_DRAWFIN;
        end else begin
          pm_raddr = rd_row_addr;
          state_d  = svc_pkg::ST_ROWMOD;
        end
      end
      svc_pkg::ST_ROWMOD: begin
        ds_we    = 1'b1;
        dvalid_d[yabs[svc_pkg::RowW-1:0]] = 1'b1;
        hit_d    = hit_q | (|(drow & spr));
        r_d      = r_q + 1'b1;
        state_d  = svc_pkg::ST_ROWRD;
      end
      svc_pkg::ST_DRAWFIN: begin
        vr_we    = hit_q;
        vr_waddr = 4'hF;
        vr_wdata = 8'h01;
        res_d.collision = hit_q;
        resv_d   = 1'b1;
        state_d  = svc_pkg::ST_IDLE;
      end
      default: state_d = svc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= svc_pkg::ST_CLEAR;
      clr_q    <= '0;
      pc_q     <= svc_pkg::PcReset;
      i_q      <= '0;
      vvalid_q <= '0;
      dvalid_q <= '0;
      resv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pc_q     <= pc_d;
      i_q      <= i_d;
      vvalid_q <= vvalid_d;
      dvalid_q <= dvalid_d;
      resv_q   <= resv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q       <= hi_d;
    instr_q    <= instr_d;
    x0_q       <= x0_d;
    y0_q       <= y0_d;
    r_q        <= r_d;
    hit_q      <= hit_d;
    res_q      <= res_d;
    vr_raddr_q <= vr_raddr;
    ds_raddr_q <= ds_raddr;
    if (state_q == svc_pkg::ST_IDLE) begin
      in_row_q <= in_i.row_select;
    end
  end

  assign busy        = (state_q != svc_pkg::ST_IDLE);
  assign res_valid_o = resv_q;
  assign res_o       = res_q;
endmodule
`default_nettype wire

[sv/svc_checker.sv]
// Port-level checks for the sprite VM core, bound to the top level.
// Depends on svc_pkg and sprite_vm_core_subset_core.
`timescale 1ns / 1ps
`default_nettype none
module svc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               res_valid_o,
  input wire svc_pkg::item_out_t res_o
);
  // an accepted item is either being worked on or answered next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || res_valid_o)) else $error("item dropped");

  // no result without a preceding accept or busy period
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy || start)) else $error("result invented");

  // an unsupported instruction never reports a collision
  a_unsup_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.unsupported) |-> !res_o.collision)
    else $error("unsupported with collision");

  // row data only comes with read items, which fetch no instruction
  a_row_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.row_pixels != 64'd0) |-> res_o.instruction == 16'd0)
    else $error("row data on execute result");
endmodule

bind sprite_vm_core_subset_core svc_checker u_svc_checker (.*);
`default_nettype wire
